[hw/rtl/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg
// types, token kinds, character constants and character classes shared by
// the token scanner
// ----------------------------------------------------------------------------
package cts_pkg;

    // token kinds
    localparam logic [3:0] KIND_END    = 4'd0;
    localparam logic [3:0] KIND_NUM    = 4'd1;
    localparam logic [3:0] KIND_INT    = 4'd2;
    localparam logic [3:0] KIND_RETURN = 4'd3;
    localparam logic [3:0] KIND_IDENT  = 4'd4;
    localparam logic [3:0] KIND_OP     = 4'd5;
    localparam logic [3:0] KIND_LPAREN = 4'd6;
    localparam logic [3:0] KIND_RPAREN = 4'd7;
    localparam logic [3:0] KIND_LBRACE = 4'd8;
    localparam logic [3:0] KIND_RBRACE = 4'd9;
    localparam logic [3:0] KIND_SEMI   = 4'd10;

    // source bytes with a meaning of their own
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // keyword lengths
    localparam logic [7:0] KW_INT_LEN    = 8'd3;
    localparam logic [7:0] KW_RETURN_LEN = 8'd6;

    // one emitted token
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] token_len;
        logic       len_saturated;
        logic [7:0] token_byte;
        logic       last_of_item;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // byte at position p of "int" matches c
    function automatic logic int_char_ok(input logic [7:0] p, input logic [7:0] c);
        logic ok;
        unique case (p)
            8'd0:    ok = (c == "i");
            8'd1:    ok = (c == "n");
            8'd2:    ok = (c == "t");
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // byte at position p of "return" matches c
    function automatic logic ret_char_ok(input logic [7:0] p, input logic [7:0] c);
        logic ok;
        unique case (p)
            8'd0:    ok = (c == "r");
            8'd1:    ok = (c == "e");
            8'd2:    ok = (c == "t");
            8'd3:    ok = (c == "u");
            8'd4:    ok = (c == "r");
            8'd5:    ok = (c == "n");
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

[hw/rtl/c_subset_token_scanner_top.sv]
// ----------------------------------------------------------------------------
// c_subset_token_scanner_top
// one-byte-per-cycle scanner for a small subset of c: numbers, identifiers,
// the keywords int and return, operators and punctuation
// ----------------------------------------------------------------------------
// path: a byte is held in the input register and scanned there; its tokens are
//   written into the token queue and shown on the master side from its head
// throughput: one byte per cycle, set by the combinational scan step; a byte
//   is taken while the four-entry token queue holds two free slots, so a byte
//   that yields two tokens hands them to the master side one at a time
// reset: rst_n asynchronous, active low; clears scan state, input register
//   valid and queue pointers; scanner comes up idle between tokens
// ----------------------------------------------------------------------------
module c_subset_token_scanner_top
    import cts_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side: source bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_text
    // master side: tokens
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] kind, [11:4] token_len,
                                   // [12] len_saturated, [20:13] token_byte, zero pad
    output logic        m_tlast    // last_of_item
);

    // run length saturates at the smaller of the parameter and the field width
    localparam logic [7:0] LEN_LIMIT = (MAX_TOKEN_LEN < 255) ? 8'(MAX_TOKEN_LEN) : 8'd255;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_HALT
    } mode_t;

    // scan state
    mode_t      mode_reg, mode_next;
    logic [7:0] run_len_reg, run_len_next;
    logic       run_ovf_reg, run_ovf_next;
    logic       int_match_reg, int_match_next;
    logic       ret_match_reg, ret_match_next;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_eot_reg;

    // token queue
    token_t          queue_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]    count_reg;

    logic       advance;
    logic       pop;
    logic [1:0] push_n;
    token_t     res0, res1;
    token_t     head;

    // a byte moves on once two queue slots are surely free
    assign advance  = in_valid_reg && (count_reg <= (QAW+1)'(QDEPTH - 2));
    assign s_tready = !in_valid_reg || advance;

    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {3'b000, head.token_byte, head.len_saturated, head.token_len, head.kind};
    assign m_tlast  = head.last_of_item;
    assign pop      = m_tvalid && m_tready;

    // scan step on the registered byte
    always_comb
    begin
        logic [7:0] c;
        logic       eot;
        logic       in_run;
        logic       cont;
        logic [3:0] run_kind;
        token_t     single;
        logic       has_single;

        c          = in_ch_reg;
        eot        = in_eot_reg;
        mode_next      = mode_reg;
        run_len_next   = run_len_reg;
        run_ovf_next   = run_ovf_reg;
        int_match_next = int_match_reg;
        ret_match_next = ret_match_reg;
        res0       = '0;
        res1       = '0;
        push_n     = 2'd0;
        single     = '0;
        has_single = 1'b0;
        in_run     = (mode_reg == MODE_NUM) || (mode_reg == MODE_IDENT);
        cont       = !eot && (is_digit(c) || ((mode_reg == MODE_IDENT) && is_letter(c)));

        // kind of the pending run if it ends here
        run_kind = KIND_NUM;
        if (mode_reg == MODE_IDENT)
        begin
            if (!run_ovf_reg && int_match_reg && (run_len_reg == KW_INT_LEN))
                run_kind = KIND_INT;
            else if (!run_ovf_reg && ret_match_reg && (run_len_reg == KW_RETURN_LEN))
                run_kind = KIND_RETURN;
            else
                run_kind = KIND_IDENT;
        end

        if (mode_reg == MODE_HALT)
        begin
            push_n = 2'd0;
        end
        else if (in_run && cont)
        begin
            // run goes on
            int_match_next = int_match_reg && int_char_ok(run_len_reg, c);
            ret_match_next = ret_match_reg && ret_char_ok(run_len_reg, c);
            if (run_len_reg < LEN_LIMIT)
                run_len_next = run_len_reg + 8'd1;
            else
                run_ovf_next = 1'b1;
        end
        else
        begin
            if (in_run)
            begin
                // run ends: its token goes first
                res0.kind          = run_kind;
                res0.token_len     = run_len_reg;
                res0.len_saturated = run_ovf_reg;
                mode_next      = MODE_IDLE;
                run_len_next   = 8'd0;
                run_ovf_next   = 1'b0;
                int_match_next = 1'b0;
                ret_match_next = 1'b0;
            end

            // then the byte itself is scanned
            single.token_len  = 8'd1;
            single.token_byte = c;
            priority if (eot)
            begin
                single     = '0;
                has_single = 1'b1;
                mode_next  = MODE_HALT;
            end
            else if (is_space(c))
            begin
                has_single = 1'b0;
            end
            else if (is_digit(c) || is_letter(c))
            begin
                // new run, first byte counted
                mode_next      = is_digit(c) ? MODE_NUM : MODE_IDENT;
                run_len_next   = 8'd1;
                run_ovf_next   = 1'b0;
                int_match_next = (c == "i");
                ret_match_next = (c == "r");
            end
            else if ((c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH))
            begin
                single.kind = KIND_OP;
                has_single  = 1'b1;
            end
            else if (c == CH_LPAREN)
            begin
                single.kind = KIND_LPAREN;
                has_single  = 1'b1;
            end
            else if (c == CH_RPAREN)
            begin
                single.kind = KIND_RPAREN;
                has_single  = 1'b1;
            end
            else if (c == CH_LBRACE)
            begin
                single.kind = KIND_LBRACE;
                has_single  = 1'b1;
            end
            else if (c == CH_RBRACE)
            begin
                single.kind = KIND_RBRACE;
                has_single  = 1'b1;
            end
            else if (c == CH_SEMI)
            begin
                single.kind = KIND_SEMI;
                has_single  = 1'b1;
            end
            else
            begin
                // invalid byte ends the text
                single     = '0;
                has_single = 1'b1;
                mode_next  = MODE_HALT;
            end

            single.last_of_item = 1'b1;
            if (in_run)
            begin
                if (has_single)
                begin
                    res1   = single;
                    push_n = 2'd2;
                end
                else
                begin
                    res0.last_of_item = 1'b1;
                    push_n = 2'd1;
                end
            end
            else if (has_single)
            begin
                res0   = single;
                push_n = 2'd1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            run_len_reg   <= 8'd0;
            run_ovf_reg   <= 1'b0;
            int_match_reg <= 1'b0;
            ret_match_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg      <= mode_next;
                run_len_reg   <= run_len_next;
                run_ovf_reg   <= run_ovf_next;
                int_match_reg <= int_match_next;
                ret_match_reg <= ret_match_next;
            end
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                wr_ptr_reg <= wr_ptr_reg + QAW'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            count_reg <= count_reg + (QAW+1)'(advance ? push_n : 2'd0)
                         - (QAW+1)'(pop);
        end
    end

    // payload: input byte and queued tokens
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_ch_reg  <= s_tdata;
            in_eot_reg <= s_tlast;
        end
        if (advance && (push_n != 2'd0))
            queue_reg[wr_ptr_reg] <= res0;
        if (advance && (push_n == 2'd2))
            queue_reg[wr_ptr_reg + QAW'(1)] <= res1;
    end

endmodule
